// ===== hw/rtl/sdr_pkg.sv =====
`default_nettype none

package sdr_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_CAP   = 2'd1;

  localparam int LINE_W  = 13;
  localparam int CAP_W   = 8;
  localparam int COL_W   = 12;
  localparam int DISP_W  = 13;
  localparam int PIX_W   = 8;
  localparam int RCOL_W  = 14;   // signed right column, column - d +/- 1
  localparam int DEN_W   = 10;   // 2*den <= 1020
  localparam int OUT_W   = 21;

  localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 13'd640;
  localparam logic [CAP_W-1:0]  COST_CAP_RST   = 8'd20;

  // per-item control carried alongside the divider
  typedef struct packed {
    logic              refine;
    logic              neg;
    logic              dneg;
    logic [DISP_W-1:0] disp;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdr_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The quotient is known to fit FRAC_BITS bits, so the top of the
// dividend already sits below the divisor and only the low bits iterate.
module sdr_div #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [FRAC_BITS+sdr_pkg::DEN_W-2:0]    in_num,
  input  wire logic [sdr_pkg::DEN_W-1:0]              in_dvs,
  input  wire sdr_pkg::side_t                         in_side,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [FRAC_BITS-1:0]                        out_quo,
  output sdr_pkg::side_t                              out_side
);

  localparam int DW = sdr_pkg::DEN_W;

  logic                 vld  [FRAC_BITS];
  logic [DW-1:0]        rem  [FRAC_BITS];
  logic [FRAC_BITS-1:0] low  [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo  [FRAC_BITS];
  logic [DW-1:0]        dvs  [FRAC_BITS];
  sdr_pkg::side_t       side [FRAC_BITS];
  logic                 take [FRAC_BITS+1];

  assign take[FRAC_BITS] = !out_stall;
  assign in_stall        = !take[0];

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
    logic                 vld_in;
    logic [DW-1:0]        rem_in;
    logic [FRAC_BITS-1:0] low_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [DW-1:0]        dvs_in;
    sdr_pkg::side_t       side_in;
    logic [DW:0]          trial;
    logic [DW:0]          diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = {1'b0, in_num[FRAC_BITS+DW-2:FRAC_BITS]};
      assign low_in  = in_num[FRAC_BITS-1:0];
      assign quo_in  = '0;
      assign dvs_in  = in_dvs;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[s-1];
      assign rem_in  = rem[s-1];
      assign low_in  = low[s-1];
      assign quo_in  = quo[s-1];
      assign dvs_in  = dvs[s-1];
      assign side_in = side[s-1];
    end

    assign trial   = {rem_in, low_in[FRAC_BITS-1]};
    assign diff    = trial - {1'b0, dvs_in};
    assign ge      = trial >= {1'b0, dvs_in};
    assign take[s] = !vld[s] || take[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (take[s]) begin
        vld[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (take[s]) begin
        rem[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[s]  <= {low_in[FRAC_BITS-2:0], 1'b0};
        quo[s]  <= {quo_in[FRAC_BITS-2:0], ge};
        dvs[s]  <= dvs_in;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[FRAC_BITS-1];
  assign out_quo   = quo[FRAC_BITS-1];
  assign out_side  = side[FRAC_BITS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/subpixel_disparity_refine.sv =====
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_stall   column, int_disparity, left_pixel,
//                                right_for_minus, right_for_centre, right_for_plus
// out      out_valid / out_stall refined_disparity, was_refined
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low. The stages in order:
// cost stage, parabola setup stage, one divider stage per fraction bit,
// output register. Every stage holds a valid bit and fills bubbles when
// out_stall is high. Reset clears the valid bits and loads line_width = 640,
// cost_cap = 20. Configuration writes are taken every cycle.
module subpixel_disparity_refine #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int FRACTION_BITS  = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sdr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [sdr_pkg::COL_W-1:0]            column,
  input  wire logic signed [sdr_pkg::DISP_W-1:0]    int_disparity,
  input  wire logic [sdr_pkg::PIX_W-1:0]            left_pixel,
  input  wire logic [sdr_pkg::PIX_W-1:0]            right_for_minus,
  input  wire logic [sdr_pkg::PIX_W-1:0]            right_for_centre,
  input  wire logic [sdr_pkg::PIX_W-1:0]            right_for_plus,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [sdr_pkg::OUT_W-1:0]          refined_disparity,
  output logic                                      was_refined
);

  localparam int MaxW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int WCmpW  = (MaxW > sdr_pkg::LINE_W) ? MaxW : sdr_pkg::LINE_W;
  localparam int NumW   = FRACTION_BITS + sdr_pkg::DEN_W - 1;
  localparam int AccW   = (sdr_pkg::DISP_W + FRACTION_BITS + 2 > sdr_pkg::OUT_W)
                          ? sdr_pkg::DISP_W + FRACTION_BITS + 2 : sdr_pkg::OUT_W;
  localparam int RW     = sdr_pkg::RCOL_W;
  localparam int CW     = sdr_pkg::CAP_W;

  // ---------------- configuration ----------------
  logic [sdr_pkg::LINE_W-1:0] line_width;
  logic [CW-1:0]              cost_cap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= sdr_pkg::LINE_WIDTH_RST;
      cost_cap   <= sdr_pkg::COST_CAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdr_pkg::REG_LINE_WIDTH: line_width <= cfg_data;
        sdr_pkg::REG_COST_CAP:   cost_cap   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  logic [WCmpW-1:0] width_eff;
  assign width_eff = (WCmpW'(line_width) > WCmpW'(MAX_LINE_WIDTH))
                     ? WCmpW'(MAX_LINE_WIDTH) : WCmpW'(line_width);

  // ---------------- handshake chain ----------------
  logic v1, v2;
  logic take1, take2, take_o;
  logic div_in_stall, div_out_valid;

  assign take_o   = !out_valid || !out_stall;
  assign take2    = !v2 || !div_in_stall;
  assign take1    = !v1 || take2;
  assign in_stall = !take1;

  // ---------------- stage 1: costs ----------------
  logic signed [RW-1:0] rc_col, rm_col, rp_col;
  logic                 in_m, in_c, in_p;
  logic [CW-1:0]        cost_m, cost_c, cost_p;

  assign rc_col = RW'($signed({1'b0, column})) - RW'(int_disparity);
  assign rm_col = rc_col + RW'(1);
  assign rp_col = rc_col - RW'(1);

  function automatic logic inside_line(input logic signed [RW-1:0] r,
                                       input logic [WCmpW-1:0] w);
    return !r[RW-1] && (WCmpW'(r[RW-2:0]) < w);
  endfunction

  function automatic logic [CW-1:0] ad_cost(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return (d < cap) ? d : cap;
  endfunction

  assign in_m   = inside_line(rm_col, width_eff);
  assign in_c   = inside_line(rc_col, width_eff);
  assign in_p   = inside_line(rp_col, width_eff);
  assign cost_m = ad_cost(left_pixel, right_for_minus, cost_cap);
  assign cost_c = ad_cost(left_pixel, right_for_centre, cost_cap);
  assign cost_p = ad_cost(left_pixel, right_for_plus, cost_cap);

  logic [CW-1:0]              s1_cm, s1_c0, s1_cp;
  logic                       s1_ok;
  logic [sdr_pkg::DISP_W-1:0] s1_disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (take1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      s1_cm   <= cost_m;
      s1_c0   <= cost_c;
      s1_cp   <= cost_p;
      s1_ok   <= in_m && in_c && in_p;
      s1_disp <= int_disparity;
    end
  end

  // ---------------- stage 2: parabola setup ----------------
  logic [sdr_pkg::DEN_W-1:0] den;
  logic [CW-1:0]             mag;
  logic                      centre_low;
  logic [NumW-1:0]           num_next;
  logic [sdr_pkg::DEN_W-1:0] dvs_next;
  sdr_pkg::side_t            side_next;

  assign centre_low = (s1_c0 <= s1_cm) && (s1_c0 <= s1_cp);
  assign den = {2'b00, s1_cm} + {2'b00, s1_cp} - {1'b0, s1_c0, 1'b0};
  assign mag = (s1_cm >= s1_cp) ? s1_cm - s1_cp : s1_cp - s1_cm;
  // dividend mag*2^F + den gives round-half-up of mag*2^F / (2*den)
  assign num_next = ({1'b0, mag, FRACTION_BITS'(0)}) + NumW'(den);
  assign dvs_next = {den[sdr_pkg::DEN_W-2:0], 1'b0};

  always_comb begin
    side_next.refine = s1_ok && centre_low && (den != '0);
    side_next.neg    = s1_cp > s1_cm;
    side_next.dneg   = s1_disp[sdr_pkg::DISP_W-1];
    side_next.disp   = s1_disp;
  end

  logic [NumW-1:0]           s2_num;
  logic [sdr_pkg::DEN_W-1:0] s2_dvs;
  sdr_pkg::side_t            s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (take2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_num  <= num_next;
      s2_dvs  <= dvs_next;
      s2_side <= side_next;
    end
  end

  // ---------------- divider ----------------
  logic [FRACTION_BITS-1:0] quo;
  sdr_pkg::side_t           div_side;

  sdr_div #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_stall  (div_in_stall),
    .in_num    (s2_num),
    .in_dvs    (s2_dvs),
    .in_side   (s2_side),
    .out_valid (div_out_valid),
    .out_stall (!take_o),
    .out_quo   (quo),
    .out_side  (div_side)
  );

  // ---------------- output stage ----------------
  localparam logic [FRACTION_BITS-1:0] Half = FRACTION_BITS'(1) << (FRACTION_BITS - 1);

  logic [FRACTION_BITS-1:0] quo_clamp;
  logic signed [AccW-1:0]   base;
  logic signed [AccW-1:0]   res;
  logic                     apply;

  assign quo_clamp = (quo > Half) ? Half : quo;
  assign apply     = div_side.refine && !div_side.dneg;
  assign base      = div_side.dneg
                     ? -(AccW'(1) <<< FRACTION_BITS)
                     : (AccW'(div_side.disp) <<< FRACTION_BITS);
  assign res       = !apply ? base
                     : div_side.neg ? base - AccW'(quo_clamp)
                                    : base + AccW'(quo_clamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_o) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      refined_disparity <= res[sdr_pkg::OUT_W-1:0];
      was_refined       <= apply;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_LINE     = 4096;
  localparam int FRAC         = 8;
  localparam int SCALE        = 1 << FRAC;
  localparam int SETTLE       = 2 * (FRAC + 3) + 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int RUN_LIMIT    = 200000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_PIXELS = 155;

  typedef struct packed {
    logic [sdr_pkg::COL_W-1:0]         column;
    logic signed [sdr_pkg::DISP_W-1:0] disp;
    logic [sdr_pkg::PIX_W-1:0]         left;
    logic [sdr_pkg::PIX_W-1:0]         r_minus;
    logic [sdr_pkg::PIX_W-1:0]         r_centre;
    logic [sdr_pkg::PIX_W-1:0]         r_plus;
  } pixel_t;

  typedef struct packed {
    logic signed [sdr_pkg::OUT_W-1:0] disp;
    logic                             refined;
  } result_t;

  typedef enum int {PX_PARABOLA, PX_EDGE, PX_NOISE, PX_NOMATCH} px_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sdr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [sdr_pkg::COL_W-1:0]         column = '0;
  logic signed [sdr_pkg::DISP_W-1:0] int_disparity = '0;
  logic [sdr_pkg::PIX_W-1:0]         left_pixel = '0;
  logic [sdr_pkg::PIX_W-1:0]         right_for_minus = '0;
  logic [sdr_pkg::PIX_W-1:0]         right_for_centre = '0;
  logic [sdr_pkg::PIX_W-1:0]         right_for_plus = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [sdr_pkg::OUT_W-1:0] refined_disparity;
  logic                             was_refined;

  // shadow copy of the block's registers
  logic [sdr_pkg::LINE_W-1:0] line_w_cfg = sdr_pkg::LINE_WIDTH_RST;
  logic [sdr_pkg::CAP_W-1:0]  cap_cfg = sdr_pkg::COST_CAP_RST;

  pixel_t  pixel_q[$];
  result_t refined_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;

  int errors = 0;
  int accepted_count = 0;
  int refined_count = 0;
  int settings_count = 1;
  int cycle_count = 0;

  subpixel_disparity_refine #(
    .MAX_LINE_WIDTH(MAX_LINE),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .column(column),
    .int_disparity(int_disparity),
    .left_pixel(left_pixel),
    .right_for_minus(right_for_minus),
    .right_for_centre(right_for_centre),
    .right_for_plus(right_for_plus),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .refined_disparity(refined_disparity),
    .was_refined(was_refined)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int match_cost(int lp, int rp, int rcol, int width, int cap);
    int diff;
    if (rcol < 0 || rcol >= width) return cap + 1;
    diff = (lp > rp) ? lp - rp : rp - lp;
    return (diff < cap) ? diff : cap;
  endfunction

  function automatic result_t refine_disparity(pixel_t px);
    result_t r;
    int d, col, width, cap, cm, c0, cp, den, num, mag, q, fixed;
    d = $signed(px.disp);
    col = px.column;
    width = (line_w_cfg > MAX_LINE) ? MAX_LINE : line_w_cfg;
    cap = cap_cfg;
    r.refined = 1'b0;
    if (d < 0) begin
      fixed = -SCALE;
    end else begin
      fixed = d * SCALE;
      cm = match_cost(px.left, px.r_minus, col - d + 1, width, cap);
      c0 = match_cost(px.left, px.r_centre, col - d, width, cap);
      cp = match_cost(px.left, px.r_plus, col - d - 1, width, cap);
      if (cm <= cap && c0 <= cap && cp <= cap && c0 <= cm && c0 <= cp) begin
        den = cm - 2 * c0 + cp;
        if (den != 0) begin
          num = cm - cp;
          mag = (num < 0) ? -num : num;
          // round half away from zero on the magnitude
          q = (mag * SCALE + den) / (2 * den);
          if (q > SCALE / 2) q = SCALE / 2;
          fixed = (num < 0) ? fixed - q : fixed + q;
          r.refined = 1'b1;
        end
      end
    end
    r.disp = fixed[sdr_pkg::OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [sdr_pkg::PIX_W-1:0] near_pixel(int base, int dev);
    int v;
    v = ($urandom_range(1) != 0) ? base + dev : base - dev;
    if (v > 255) v = base - dev;
    if (v < 0) v = base + dev;
    if (v > 255) v = 255;
    return v[sdr_pkg::PIX_W-1:0];
  endfunction

  function automatic pixel_t mk_pixel(int col, int d, int lp, int rm, int rc, int rp);
    pixel_t px;
    px.column = sdr_pkg::COL_W'(col);
    px.disp = sdr_pkg::DISP_W'(d);
    px.left = sdr_pkg::PIX_W'(lp);
    px.r_minus = sdr_pkg::PIX_W'(rm);
    px.r_centre = sdr_pkg::PIX_W'(rc);
    px.r_plus = sdr_pkg::PIX_W'(rp);
    return px;
  endfunction

  // mostly pixels whose three right columns sit inside the line with a
  // cost dip at the centre; the rest probe line edges, noise and no-match
  function automatic pixel_t make_pixel();
    pixel_t px;
    px_kind_t kind;
    int w, cap, d, col, hi, dev0, pick, off;
    logic shaped;
    w = (line_w_cfg > MAX_LINE) ? MAX_LINE : line_w_cfg;
    cap = cap_cfg;
    pick = $urandom_range(99);
    if (pick < 60) kind = PX_PARABOLA;
    else if (pick < 75) kind = PX_EDGE;
    else if (pick < 90) kind = PX_NOISE;
    else kind = PX_NOMATCH;
    if (kind == PX_PARABOLA && w < 3) kind = PX_EDGE;
    px = mk_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255));
    shaped = 1'b1;
    case (kind)
      PX_PARABOLA: begin
        d = ($urandom_range(1) != 0) ? $urandom_range(63) : $urandom_range(4094);
        hi = (w - 2 + d > 4095) ? 4095 : w - 2 + d;
        col = $urandom_range(hi, d + 1);
        px.column = sdr_pkg::COL_W'(col);
        px.disp = sdr_pkg::DISP_W'(d);
      end
      PX_EDGE: begin
        d = $urandom_range(4095);
        case ($urandom_range(7))
          0: off = -1;
          1: off = 0;
          2: off = 1;
          3: off = 2;
          4: off = w - 3;
          5: off = w - 2;
          6: off = w - 1;
          default: off = w;
        endcase
        col = d + off;
        if (col < 0 || col > 4095) col = $urandom_range(4095);
        px.column = sdr_pkg::COL_W'(col);
        px.disp = sdr_pkg::DISP_W'(d);
      end
      PX_NOISE: shaped = 1'b0;
      default: begin
        px.disp = sdr_pkg::DISP_W'(-1);
        shaped = 1'b0;
      end
    endcase
    if (shaped) begin
      dev0 = $urandom_range(cap / 2 + 1);
      px.r_centre = near_pixel(px.left, dev0);
      px.r_minus = near_pixel(px.left, $urandom_range(cap + 8, dev0));
      px.r_plus = near_pixel(px.left, $urandom_range(cap + 8, dev0));
    end
    return px;
  endfunction

  // input driver
  always @(posedge clk) begin
    pixel_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt = mk_pixel(column, $signed(int_disparity), left_pixel, right_for_minus,
                       right_for_centre, right_for_plus);
        refined_q.push_back(refine_disparity(nxt));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          column <= nxt.column;
          int_disparity <= nxt.disp;
          left_pixel <= nxt.left;
          right_for_minus <= nxt.r_minus;
          right_for_centre <= nxt.r_centre;
          right_for_plus <= nxt.r_plus;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (refined_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: refined_disparity %0d was_refined %0b",
                   $time, refined_disparity, was_refined);
        end else begin
          want = refined_q.pop_front();
          if (want.refined) refined_count++;
          if (refined_disparity !== want.disp) begin
            errors++;
            $display("%0t: refined_disparity expected %0d got %0d",
                     $time, $signed(want.disp), refined_disparity);
          end
          if (was_refined !== want.refined) begin
            errors++;
            $display("%0t: was_refined expected %0b got %0b",
                     $time, want.refined, was_refined);
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, refined_q.size());
      $display("[subpixel_disparity_refine] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || refined_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sdr_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sdr_pkg::REG_LINE_WIDTH) line_w_cfg = val;
    else if (idx == sdr_pkg::REG_COST_CAP) cap_cfg = val[sdr_pkg::CAP_W-1:0];
  endtask

  int lw_set[NUM_PHASES] = '{640, 4096, 1, 3, 2048, 0, 17, 0};
  int cap_set[NUM_PHASES] = '{20, 254, 0, 5, 1, -1, 254, -1};
  int send_mix[4] = '{0, 45, 0, 17};
  int recv_mix[4] = '{0, 0, 45, 17};

  initial begin
    int lw, cap;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset register values (640 columns, cap 20)
    pixel_q.push_back(mk_pixel(0, -1, 0, 0, 0, 0));
    pixel_q.push_back(mk_pixel(4095, -1, 255, 255, 255, 255));
    pixel_q.push_back(mk_pixel(0, 0, 10, 10, 10, 12));         // plus column off the left
    pixel_q.push_back(mk_pixel(1, 0, 100, 110, 100, 105));     // shift toward +
    pixel_q.push_back(mk_pixel(1, 0, 100, 105, 100, 110));     // shift toward -
    pixel_q.push_back(mk_pixel(10, 3, 50, 50, 50, 50));        // flat: zero denominator
    pixel_q.push_back(mk_pixel(10, 3, 50, 50, 60, 70));        // centre not the minimum
    pixel_q.push_back(mk_pixel(10, 3, 50, 250, 50, 0));        // both sides capped
    pixel_q.push_back(mk_pixel(4095, 4094, 0, 255, 3, 3));     // largest refined output
    pixel_q.push_back(mk_pixel(4095, 4095, 0, 5, 0, 5));
    pixel_q.push_back(mk_pixel(4095, 0, 7, 9, 7, 9));          // all right columns past the line
    pixel_q.push_back(mk_pixel(639, 0, 30, 40, 30, 35));       // minus column just past the line
    pixel_q.push_back(mk_pixel(638, 0, 30, 40, 30, 35));
    pixel_q.push_back(mk_pixel(5, 2, 0, 255, 0, 255));
    pixel_q.push_back(mk_pixel(5, 2, 255, 0, 255, 0));
    pixel_q.push_back(mk_pixel(5, 2, 100, 101, 100, 100));     // half-pixel step up
    pixel_q.push_back(mk_pixel(5, 2, 100, 100, 100, 101));     // half-pixel step down
    pixel_q.push_back(mk_pixel(2730, 1365, 170, 85, 170, 85));
    pixel_q.push_back(mk_pixel(1365, 1360, 85, 90, 86, 100));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      lw = (lw_set[ph] == 0) ? $urandom_range(4096, 1) : lw_set[ph];
      cap = (cap_set[ph] < 0) ? $urandom_range(254) : cap_set[ph];
      write_reg(sdr_pkg::REG_LINE_WIDTH, sdr_pkg::CFG_DATA_W'(lw));
      write_reg(sdr_pkg::REG_COST_CAP, sdr_pkg::CFG_DATA_W'(cap));
      cfg_valid <= 1'b0;
      settings_count++;
      send_idle_pct = send_mix[ph % 4];
      recv_stall_pct = recv_mix[ph % 4];
      if (ph == 2) begin
        // long receiver hold while the sender keeps pushing
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      for (int i = 0; i < PHASE_PIXELS; i++) pixel_q.push_back(make_pixel());
    end
    wait_idle();

    $display("checked %0d pixels, %0d with sub-pixel correction, across %0d register settings",
             accepted_count, refined_count, settings_count);
    $display("flow control: free-running, sender gaps, receiver stalls, both, one long hold");
    if (errors == 0) begin
      $display("[subpixel_disparity_refine] OK");
    end else begin
      $display("[subpixel_disparity_refine] ERROR");
    end
    $finish;
  end

endmodule
